// File: rtl/tws_pkg.sv
// Shared types, codes and defaults for the textured wall column shader.
// No dependencies; tws_front, tws_back and the shader unit use it by scoped names.
package tws_pkg;

    // Default geometry. TEX_SIZE must be a power of two.
    localparam int SCREEN_HEIGHT_DEF = 512;
    localparam int TEX_SIZE_DEF      = 64;
    localparam int TEXTURE_COUNT_DEF = 8;

    // Queue depths: the item queue covers the front latency, the output
    // buffer covers the back latency, so the block streams one pixel a clock unless the output stalls.
    localparam int QUEUE_DEPTH = 32;
    localparam int OUT_DEPTH   = 16;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_CEILING = 2'd0;
    localparam logic [1:0] CFG_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_PROJ    = 2'd2;

    localparam logic [31:0] CEILING_RESET = 32'hFF383838;
    localparam logic [31:0] FLOOR_RESET   = 32'hFF707070;
    localparam logic [15:0] PROJ_RESET    = 16'd692;

    // Cosine polynomial coefficients (Q16 Horner form)
    localparam logic [16:0] COS_K0 = 17'd60;
    localparam logic [16:0] COS_K1 = 17'd1367;
    localparam logic [16:0] COS_K2 = 17'd16625;
    localparam logic [16:0] COS_K3 = 17'd80852;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  column;
        logic [8:0]  row;
        logic [23:0] ray_distance;
        logic [11:0] ray_angle;
        logic [11:0] player_angle;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic        hit_vertical;
        logic [3:0]  wall_content;
        logic [11:0] texel_address;
        logic [31:0] texel_color;
    } t_req;

    // Classified item between front and back. coord is the hit coordinate
    // for a shade and the texel address for a load.
    typedef struct packed {
        logic        cmd;
        logic [9:0]  column;
        logic [8:0]  row;
        logic [3:0]  content;
        logic [15:0] coord;
        logic [15:0] height;
        logic [31:0] color;
    } t_item;

    typedef struct packed {
        logic [9:0]  column;
        logic [8:0]  row;
        logic [31:0] color;
    } t_pix;

endpackage

// File: rtl/tws_fifo.sv
// Small register queue used between pipeline sections.
// Depends on nothing; the caller guarantees no overflow by credit counting.
module tws_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
endmodule

// File: rtl/tws_front.sv
// Front section: classify items, cosine, perpendicular distance, strip height.
// Depends on tws_pkg. Free-running pipeline; admission is credit controlled.
module tws_front #(
    parameter int TEX_SIZE = tws_pkg::TEX_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  tws_pkg::t_req        i_req,
    input  logic [15:0]          i_proj,
    output logic                 o_push,
    output tws_pkg::t_item       o_item
);
    localparam int L    = $clog2(TEX_SIZE);
    localparam int NUMW = 24 + L;
    localparam int NST  = 24;

    logic                r_vld [NST];
    tws_pkg::t_item      r_itm [NST];

    logic [23:0] r_dist [6];
    logic        r_neg  [6];
    logic [16:0] r_w2   [1:4];
    logic [10:0] r_x;
    logic [16:0] r_r2, r_r3, r_r4, r_c;
    logic [23:0] r_perp;

    logic [24:0] r_drem [17];
    logic [15:0] r_dq   [17];
    logic [23:0] r_dper [17];
    logic [15:0] r_dlo  [17];
    logic        r_dsat [17];

    logic [11:0] d;
    logic [10:0] x;
    logic        neg;
    logic [21:0] xx;
    logic [33:0] m2, m3, m4, m5;
    logic [17:0] r4v;
    logic [40:0] mp;
    logic [NUMW-1:0] num;
    logic [L+7:0]    hi;
    tws_pkg::t_item  itm0;

    always_comb begin
        d   = i_req.ray_angle - i_req.player_angle;
        neg = (d[11:10] == 2'd1) || (d[11:10] == 2'd2);
        x   = d[10] ? (11'd1024 - {1'b0, d[9:0]}) : {1'b0, d[9:0]};
        xx  = 22'(r_x) * 22'(r_x);
        m2  = 34'(r_w2[1]) * 34'(tws_pkg::COS_K0);
        m3  = 34'(r_r2) * 34'(r_w2[2]);
        m4  = 34'(r_r3) * 34'(r_w2[3]);
        m5  = 34'(r_r4) * 34'(r_w2[4]);
        r4v = 18'(m5 >> 16);
        mp  = 41'(r_dist[5]) * 41'(r_c);
        num = NUMW'(i_proj) << (L + 8);
        hi  = num[NUMW-1:16];
        itm0.cmd     = i_req.cmd;
        itm0.column  = i_req.column;
        itm0.row     = i_req.row;
        itm0.content = i_req.wall_content;
        itm0.coord   = (i_req.cmd == tws_pkg::CMD_SHADE)
                       ? (i_req.hit_vertical ? i_req.hit_y : i_req.hit_x)
                       : {4'd0, i_req.texel_address};
        itm0.height  = '0;
        itm0.color   = i_req.texel_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_itm[0] <= itm0;
        for (int k = 1; k < NST; k++) r_itm[k] <= r_itm[k-1];
        r_dist[0] <= i_req.ray_distance;
        r_neg[0]  <= neg;
        for (int k = 1; k < 6; k++) begin
            r_dist[k] <= r_dist[k-1];
            r_neg[k]  <= r_neg[k-1];
        end
        r_x     <= x;
        r_w2[1] <= 17'(xx >> 4);
        for (int k = 2; k <= 4; k++) r_w2[k] <= r_w2[k-1];
        r_r2 <= tws_pkg::COS_K1 - 17'(m2 >> 16);
        r_r3 <= tws_pkg::COS_K2 - 17'(m3 >> 16);
        r_r4 <= tws_pkg::COS_K3 - 17'(m4 >> 16);
        r_c  <= (r4v >= 18'd65536) ? 17'd0 : 17'(18'd65536 - r4v);
        r_perp <= r_neg[5] ? 24'd0 : 24'(mp >> 16);
        // seed the divider: saturate when the quotient cannot fit 16 bits
        r_drem[0] <= 25'(hi);
        r_dsat[0] <= 25'(hi) >= {1'b0, r_perp};
        r_dlo[0]  <= num[15:0];
        r_dper[0] <= r_perp;
        r_dq[0]   <= '0;
    end

    for (genvar k = 1; k <= 16; k++) begin : g_div
        logic [24:0] t;
        logic        ge;
        assign t  = {r_drem[k-1][23:0], r_dlo[k-1][16-k]};
        assign ge = t >= {1'b0, r_dper[k-1]};
        always_ff @(posedge i_clk) begin
            r_drem[k] <= ge ? t - {1'b0, r_dper[k-1]} : t;
            r_dq[k]   <= {r_dq[k-1][14:0], ge};
            r_dper[k] <= r_dper[k-1];
            r_dlo[k]  <= r_dlo[k-1];
            r_dsat[k] <= r_dsat[k-1];
        end
    end

    always_comb begin
        o_push        = r_vld[NST-1];
        o_item        = r_itm[NST-1];
        o_item.height = r_dsat[16] ? 16'hFFFF : r_dq[16];
    end
endmodule

// File: rtl/tws_back.sv
// Back section: strip bounds, texel row divide, texture store, color select.
// Depends on tws_pkg. Free-running pipeline fed from the item queue.
module tws_back #(
    parameter int SCREEN_HEIGHT = tws_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_SIZE      = tws_pkg::TEX_SIZE_DEF,
    parameter int TEXTURE_COUNT = tws_pkg::TEXTURE_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop,
    input  tws_pkg::t_item  i_item,
    input  logic [31:0]     i_ceiling,
    input  logic [31:0]     i_floor,
    output logic            o_push,
    output tws_pkg::t_pix   o_pix
);
    localparam int L     = $clog2(TEX_SIZE);
    localparam int TNW   = (TEXTURE_COUNT > 1) ? $clog2(TEXTURE_COUNT) : 1;
    localparam int ADDRW = TNW + 2 * L;
    localparam int DEPTH = TEXTURE_COUNT * TEX_SIZE * TEX_SIZE;
    localparam int NB    = L + 2;
    localparam logic [16:0] MID = 17'(SCREEN_HEIGHT / 2);
    localparam logic [16:0] SH  = 17'(SCREEN_HEIGHT);

    logic           r_vld  [NB];
    tws_pkg::t_item r_itm  [NB];
    logic           r_ceil [NB];
    logic           r_wall [NB];
    logic           r_vt   [NB];
    logic [TNW-1:0] r_tn   [NB];
    logic [16:0]    r_rem  [L+1];
    logic [L-1:0]   r_q    [L+1];

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;

    logic [14:0]      half;
    logic [16:0]      s;
    logic             ceil0, wall0, vt0;
    logic [TNW-1:0]   tn0;
    logic [ADDRW-1:0] addr;
    logic             we;

    always_comb begin
        half  = i_item.height[15:1];
        s     = 17'(i_item.row) + 17'(half);
        ceil0 = s < MID;
        wall0 = !ceil0 && (17'(i_item.row) < SH) && (17'(i_item.row) < MID + 17'(half));
        vt0   = (i_item.content != 4'd0) && (5'(i_item.content) <= 5'(TEXTURE_COUNT));
        tn0   = TNW'(i_item.content - 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_pop;
            for (int k = 1; k < NB; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_itm[0]  <= i_item;
        r_ceil[0] <= ceil0;
        r_wall[0] <= wall0;
        r_vt[0]   <= vt0;
        r_tn[0]   <= tn0;
        r_rem[0]  <= s - MID;
        r_q[0]    <= '0;
        for (int k = 1; k < NB; k++) begin
            r_itm[k]  <= r_itm[k-1];
            r_ceil[k] <= r_ceil[k-1];
            r_wall[k] <= r_wall[k-1];
            r_vt[k]   <= r_vt[k-1];
            r_tn[k]   <= r_tn[k-1];
        end
    end

    // texel row = from_top * TEX_SIZE / height, one quotient bit per stage
    for (genvar k = 1; k <= L; k++) begin : g_div
        logic [16:0] t;
        logic        ge;
        assign t  = {r_rem[k-1][15:0], 1'b0};
        assign ge = t >= {1'b0, r_itm[k-1].height};
        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? t - {1'b0, r_itm[k-1].height} : t;
            if (L > 1) begin
                r_q[k] <= L'({r_q[k-1], ge});
            end else begin
                r_q[k] <= L'(ge);
            end
        end
    end

    always_comb begin
        if (r_itm[L].cmd == tws_pkg::CMD_SHADE) begin
            addr = {r_tn[L], r_q[L], r_itm[L].coord[L-1:0]};
        end else begin
            addr = {r_tn[L], r_itm[L].coord[2*L-1:0]};
        end
        we = r_vld[L] && (r_itm[L].cmd == tws_pkg::CMD_LOAD) && r_vt[L];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= r_itm[L].color;
        end
        r_rd <= r_mem[addr];
    end

    always_comb begin
        o_push       = r_vld[NB-1] && (r_itm[NB-1].cmd == tws_pkg::CMD_SHADE);
        o_pix.column = r_itm[NB-1].column;
        o_pix.row    = r_itm[NB-1].row;
        priority if (r_ceil[NB-1]) begin
            o_pix.color = i_ceiling;
        end else if (r_wall[NB-1]) begin
            o_pix.color = r_vt[NB-1] ? r_rd : 32'd0;
        end else begin
            o_pix.color = i_floor;
        end
    end
endmodule

// File: rtl/textured_wall_column_shader_unit.sv
// Textured wall column shader: one screen pixel in, one colored pixel out.
// A load transaction (cmd 0) writes one texel if its texture number is valid
// and gives no output; a shade transaction (cmd 1) gives exactly one pixel,
// in input order. The unit streams one transaction per clock while its input
// is not stalled. A transaction passes the front section (cosine polynomial,
// distance multiply, 16-step height divider), then the item queue, then the
// back section (texel row divider and one registered read of the texture
// store), then the output buffer. The input stalls only when the 32-entry
// item queue is committed; the back section stops pulling when the 16-entry
// output buffer is committed, so downstream stalls back up through both
// queues. TEX_SIZE must be a power of two. Reading a texel never loaded
// returns undefined data. Depends on tws_pkg, tws_front, tws_fifo, tws_back.
module textured_wall_column_shader_unit #(
    parameter int SCREEN_HEIGHT = tws_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_SIZE      = tws_pkg::TEX_SIZE_DEF,
    parameter int TEXTURE_COUNT = tws_pkg::TEXTURE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [9:0]  i_column,
    input  logic [8:0]  i_row,
    input  logic [23:0] i_ray_distance,
    input  logic [11:0] i_ray_angle,
    input  logic [11:0] i_player_angle,
    input  logic [15:0] i_hit_x,
    input  logic [15:0] i_hit_y,
    input  logic        i_hit_vertical,
    input  logic [3:0]  i_wall_content,
    input  logic [11:0] i_texel_address,
    input  logic [31:0] i_texel_color,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_out_column,
    output logic [8:0]  o_out_row,
    output logic [31:0] o_pixel_color
);
    localparam int QD  = tws_pkg::QUEUE_DEPTH;
    localparam int OD  = tws_pkg::OUT_DEPTH;
    localparam int QCW = $clog2(QD + 1);
    localparam int OCW = $clog2(OD + 1);
    localparam int IW  = $bits(tws_pkg::t_item);
    localparam int PXW = $bits(tws_pkg::t_pix);

    logic [31:0] r_ceiling, r_floor;
    logic [15:0] r_proj;

    // credits: items admitted and not yet pulled from the queue, and
    // shade items pulled and not yet delivered
    logic [QCW-1:0] r_inflight;
    logic [OCW-1:0] r_bcount;

    tws_pkg::t_req  req;
    tws_pkg::t_item f_item, q_item;
    tws_pkg::t_pix  b_pix, o_pix;
    logic           accept, f_push, q_empty, q_pop, b_push, o_empty, out_acc;
    logic [IW-1:0]  q_data;
    logic [PXW-1:0] o_data;

    // hold configuration; the user must make writes arrive only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= tws_pkg::CEILING_RESET;
            r_floor   <= tws_pkg::FLOOR_RESET;
            r_proj    <= tws_pkg::PROJ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tws_pkg::CFG_CEILING: r_ceiling <= i_cfg_wdata;
                tws_pkg::CFG_FLOOR:   r_floor   <= i_cfg_wdata;
                tws_pkg::CFG_PROJ:    r_proj    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_inflight >= QCW'(QD));
    assign accept  = i_valid && !o_stall;
    assign q_item  = tws_pkg::t_item'(q_data);
    assign q_pop   = !q_empty && (r_bcount < OCW'(OD));
    assign o_valid = !o_empty;
    assign out_acc = o_valid && !i_stall;
    assign o_pix   = tws_pkg::t_pix'(o_data);

    always_comb begin
        req.cmd           = i_cmd;
        req.column        = i_column;
        req.row           = i_row;
        req.ray_distance  = i_ray_distance;
        req.ray_angle     = i_ray_angle;
        req.player_angle  = i_player_angle;
        req.hit_x         = i_hit_x;
        req.hit_y         = i_hit_y;
        req.hit_vertical  = i_hit_vertical;
        req.wall_content  = i_wall_content;
        req.texel_address = i_texel_address;
        req.texel_color   = i_texel_color;
    end

    // advance the credit counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_bcount   <= '0;
        end else begin
            r_inflight <= r_inflight + QCW'(accept) - QCW'(q_pop);
            r_bcount   <= r_bcount
                          + OCW'(q_pop && (q_item.cmd == tws_pkg::CMD_SHADE))
                          - OCW'(out_acc);
        end
    end

    tws_front #(.TEX_SIZE(TEX_SIZE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_req   (req),
        .i_proj  (r_proj),
        .o_push  (f_push),
        .o_item  (f_item)
    );

    tws_fifo #(.DEPTH(QD), .WIDTH(IW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    tws_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_SIZE      (TEX_SIZE),
        .TEXTURE_COUNT (TEXTURE_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pop     (q_pop),
        .i_item    (q_item),
        .i_ceiling (r_ceiling),
        .i_floor   (r_floor),
        .o_push    (b_push),
        .o_pix     (b_pix)
    );

    tws_fifo #(.DEPTH(OD), .WIDTH(PXW)) u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_pix),
        .i_pop   (out_acc),
        .o_data  (o_data),
        .o_empty (o_empty)
    );

    assign o_out_column  = o_pix.column;
    assign o_out_row     = o_pix.row;
    assign o_pixel_color = o_pix.color;

    // credit bookkeeping must stay within the queue sizes
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= QCW'(QD))
        else $error("item credit count above queue depth");
    a_bcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcount <= OCW'(OD))
        else $error("output credit count above buffer depth");
    // a pixel on the output must belong to a pulled shade transaction
    a_out_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_bcount != '0))
        else $error("output valid without a shade in flight");
    // the queue is never pulled beyond the admitted items
    a_pop_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (r_inflight != '0))
        else $error("queue pop without an admitted item");
endmodule

// File: bench/tws_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the textured wall column shader: watches both channels and the
// configuration port, predicts each shaded pixel, compares in order. Depends on tws_pkg.
module tws_pixel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [9:0]  i_column,
    input  logic [8:0]  i_row,
    input  logic [23:0] i_ray_distance,
    input  logic [11:0] i_ray_angle,
    input  logic [11:0] i_player_angle,
    input  logic [15:0] i_hit_x,
    input  logic [15:0] i_hit_y,
    input  logic        i_hit_vertical,
    input  logic [3:0]  i_wall_content,
    input  logic [11:0] i_texel_address,
    input  logic [31:0] i_texel_color,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [9:0]  i_out_column,
    input  logic [8:0]  i_out_row,
    input  logic [31:0] i_pixel_color,
    output int          o_errors,
    output int          o_pending
);
    localparam int SCR_H   = 512;
    localparam int TEX_W   = 64;
    localparam int TEX_NUM = 8;

    logic [31:0]   texels [TEX_NUM*TEX_W*TEX_W];
    logic [31:0]   ceiling_rgb = tws_pkg::CEILING_RESET;
    logic [31:0]   floor_rgb   = tws_pkg::FLOOR_RESET;
    logic [15:0]   proj_px     = tws_pkg::PROJ_RESET;
    tws_pkg::t_pix pixels_due [$];

    // quarter-wave cosine in Q16, x in 0..1024
    function automatic longint unsigned quarter_wave(longint unsigned x);
        longint unsigned w2;
        longint unsigned r;
        w2 = (x * x) >> 4;
        r  = tws_pkg::COS_K0;
        r  = tws_pkg::COS_K1 - ((r * w2) >> 16);
        r  = tws_pkg::COS_K2 - ((r * w2) >> 16);
        r  = tws_pkg::COS_K3 - ((r * w2) >> 16);
        r  = (r * w2) >> 16;
        return (r >= 65536) ? 0 : 65536 - r;
    endfunction

    function automatic logic [31:0] shade_color(tws_pkg::t_req q);
        logic [11:0]     d;
        logic [1:0]      quad;
        longint unsigned c, perp, num, height, tx, ty, from_top, coord;
        longint          half, top, bottom, y;
        bit              behind, good_tex;
        logic [31:0]     rgb;
        d      = q.ray_angle - q.player_angle;
        quad   = d[11:10];
        behind = (quad == 2'd1) || (quad == 2'd2);
        c      = (quad == 2'd0 || quad == 2'd2) ? quarter_wave(d[9:0])
                                                : quarter_wave(1024 - d[9:0]);
        perp   = behind ? 0 : (longint'(q.ray_distance) * c) >> 16;
        num    = longint'(TEX_W) * proj_px * 256;
        height = (perp == 0) ? 65535 : num / perp;
        if (height > 65535) height = 65535;
        half   = height >> 1;
        top    = SCR_H / 2 - half;
        bottom = SCR_H / 2 + half;
        if (top < 0) top = 0;
        if (bottom > SCR_H) bottom = SCR_H;
        y        = q.row;
        good_tex = (q.wall_content >= 1) && (q.wall_content <= TEX_NUM);
        if (y < top) begin
            rgb = ceiling_rgb;
        end else if (y < bottom) begin
            rgb = '0;
            if (good_tex && height != 0) begin
                coord    = q.hit_vertical ? q.hit_y : q.hit_x;
                tx       = coord % TEX_W;
                from_top = y + half - SCR_H / 2;
                ty       = (from_top * TEX_W) / height;
                if (ty >= TEX_W) ty = TEX_W - 1;
                rgb = texels[(q.wall_content - 1) * TEX_W * TEX_W + ty * TEX_W + tx];
            end
        end else begin
            rgb = floor_rgb;
        end
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        tws_pkg::t_req q;
        tws_pkg::t_pix want;
        if (!i_rst_n) begin
            ceiling_rgb = tws_pkg::CEILING_RESET;
            floor_rgb   = tws_pkg::FLOOR_RESET;
            proj_px     = tws_pkg::PROJ_RESET;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tws_pkg::CFG_CEILING: ceiling_rgb = i_cfg_wdata;
                    tws_pkg::CFG_FLOOR:   floor_rgb   = i_cfg_wdata;
                    tws_pkg::CFG_PROJ:    proj_px     = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                q.cmd           = i_cmd;
                q.column        = i_column;
                q.row           = i_row;
                q.ray_distance  = i_ray_distance;
                q.ray_angle     = i_ray_angle;
                q.player_angle  = i_player_angle;
                q.hit_x         = i_hit_x;
                q.hit_y         = i_hit_y;
                q.hit_vertical  = i_hit_vertical;
                q.wall_content  = i_wall_content;
                q.texel_address = i_texel_address;
                q.texel_color   = i_texel_color;
                if (q.cmd == tws_pkg::CMD_LOAD) begin
                    // drop loads to a texture that does not exist
                    if (q.wall_content >= 1 && q.wall_content <= TEX_NUM)
                        texels[(q.wall_content - 1) * TEX_W * TEX_W + q.texel_address]
                            = q.texel_color;
                end else begin
                    want.column = q.column;
                    want.row    = q.row;
                    want.color  = shade_color(q);
                    pixels_due.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    o_errors++;
                    $display("%0t unexpected pixel: expected none, actual col %0d row %0d %h",
                             $time, i_out_column, i_out_row, i_pixel_color);
                end else begin
                    want = pixels_due.pop_front();
                    if (i_out_column !== want.column) begin
                        o_errors++;
                        $display("%0t out_column mismatch: expected %0d actual %0d",
                                 $time, want.column, i_out_column);
                    end
                    if (i_out_row !== want.row) begin
                        o_errors++;
                        $display("%0t out_row mismatch: expected %0d actual %0d",
                                 $time, want.row, i_out_row);
                    end
                    if (i_pixel_color !== want.color) begin
                        o_errors++;
                        $display("%0t pixel_color mismatch: expected %h actual %h",
                                 $time, want.color, i_pixel_color);
                    end
                end
            end
        end
        o_pending = pixels_due.size();
    end
endmodule

// File: bench/tb_textured_wall_column_shader_unit.sv
`timescale 1ns / 100ps
// Top of the shader testbench: clock, reset, stimulus, configuration phases and verdict.
// Depends on tws_pkg, the shader unit and tws_pixel_checker.
module tb_textured_wall_column_shader_unit;
    localparam int TEX_W   = 64;
    localparam int TEX_NUM = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [9:0]  i_column;
    logic [8:0]  i_row;
    logic [23:0] i_ray_distance;
    logic [11:0] i_ray_angle;
    logic [11:0] i_player_angle;
    logic [15:0] i_hit_x;
    logic [15:0] i_hit_y;
    logic        i_hit_vertical;
    logic [3:0]  i_wall_content;
    logic [11:0] i_texel_address;
    logic [31:0] i_texel_color;
    logic        o_valid;
    logic        i_stall;
    logic [9:0]  o_out_column;
    logic [8:0]  o_out_row;
    logic [31:0] o_pixel_color;

    int errors;
    int pending;
    bit quiet = 1'b0;     // set for the last phase: no idling on either side

    // texture columns fully loaded, per texture; only these may be read by a wall pixel
    int loaded_cols [TEX_NUM][$];

    textured_wall_column_shader_unit dut (.*);

    tws_pixel_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_cmd, .i_column, .i_row, .i_ray_distance, .i_ray_angle, .i_player_angle,
        .i_hit_x, .i_hit_y, .i_hit_vertical, .i_wall_content, .i_texel_address,
        .i_texel_color,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_column(o_out_column), .i_out_row(o_out_row), .i_pixel_color(o_pixel_color),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // downstream stall bursts
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Drive one transaction, hold it until accepted, then maybe idle a burst.
    task automatic send(tws_pkg::t_req q);
        i_cmd           <= q.cmd;
        i_column        <= q.column;
        i_row           <= q.row;
        i_ray_distance  <= q.ray_distance;
        i_ray_angle     <= q.ray_angle;
        i_player_angle  <= q.player_angle;
        i_hit_x         <= q.hit_x;
        i_hit_y         <= q.hit_y;
        i_hit_vertical  <= q.hit_vertical;
        i_wall_content  <= q.wall_content;
        i_texel_address <= q.texel_address;
        i_texel_color   <= q.texel_color;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    function automatic tws_pkg::t_req texel_load(logic [3:0] content, logic [11:0] addr);
        tws_pkg::t_req q;
        q               = tws_pkg::t_req'({$urandom, $urandom, $urandom, $urandom});
        q.cmd           = tws_pkg::CMD_LOAD;
        q.wall_content  = content;
        q.texel_address = addr;
        q.texel_color   = $urandom;
        return q;
    endfunction

    // Write every row of one texture column so later wall pixels may sample it.
    task automatic fill_column(int tex, int tx);
        for (int ty = 0; ty < TEX_W; ty++)
            send(texel_load(tex + 1, ty * TEX_W + tx));
        loaded_cols[tex].push_back(tx);
    endtask

    // Random shade aimed mostly at visible walls; the hit coordinate always lands
    // on a loaded column of the chosen texture, or the texture number is bad.
    function automatic tws_pkg::t_req random_shade();
        tws_pkg::t_req q;
        int            tex;
        int            tx;
        q      = tws_pkg::t_req'({$urandom, $urandom, $urandom, $urandom});
        q.cmd  = tws_pkg::CMD_SHADE;
        case ($urandom_range(0, 9))
            0:       q.ray_distance = '0;
            1:       q.ray_distance = $urandom;
            2, 3:    q.ray_distance = $urandom_range(256, 8000);
            default: q.ray_distance = $urandom_range(8000, 600000);
        endcase
        if ($urandom_range(0, 9) < 7)
            q.ray_angle = q.player_angle + $urandom_range(0, 1400) - 700;
        if ($urandom_range(0, 6) == 0) begin
            q.wall_content = ($urandom_range(0, 1) == 0) ? 4'd0 : $urandom_range(9, 15);
        end else begin
            tex            = $urandom_range(0, TEX_NUM - 1);
            tx             = loaded_cols[tex][$urandom_range(0, loaded_cols[tex].size() - 1)];
            q.wall_content = tex + 1;
            if (q.hit_vertical) q.hit_y[5:0] = tx;
            else                q.hit_x[5:0] = tx;
        end
        return q;
    endfunction

    // Let the block go idle: all pixels out, then room for loads still in flight.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] ceil_rgb, logic [31:0] floor_rgb,
                              logic [15:0] proj);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tws_pkg::CFG_CEILING;
        i_cfg_wdata <= ceil_rgb;
        @(posedge i_clk);
        i_cfg_index <= tws_pkg::CFG_FLOOR;
        i_cfg_wdata <= floor_rgb;
        @(posedge i_clk);
        i_cfg_index <= tws_pkg::CFG_PROJ;
        i_cfg_wdata <= {16'h0, proj};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        tws_pkg::t_req q;
        int            tex;
        int            tx;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = tws_pkg::CFG_CEILING;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_cmd           = tws_pkg::CMD_LOAD;
        i_column        = '0;
        i_row           = '0;
        i_ray_distance  = '0;
        i_ray_angle     = '0;
        i_player_angle  = '0;
        i_hit_x         = '0;
        i_hit_y         = '0;
        i_hit_vertical  = 1'b0;
        i_wall_content  = '0;
        i_texel_address = '0;
        i_texel_color   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Preload: one random column per texture, plus both edge columns of texture one.
        fill_column(0, 0);
        fill_column(0, TEX_W - 1);
        for (int t = 0; t < TEX_NUM; t++)
            fill_column(t, $urandom_range(1, TEX_W - 2));

        // Directed corners at reset configuration.
        q = random_shade(); q.ray_distance = '0; q.row = 0;   send(q);  // zero distance
        q = random_shade(); q.ray_distance = '0; q.row = 511; send(q);
        q = random_shade(); q.ray_angle = 12'd2048; q.player_angle = '0; send(q); // behind
        q = random_shade(); q.ray_angle = 12'd1024; q.player_angle = '0; send(q);
        q = random_shade(); q.ray_angle = 12'd0; q.player_angle = 12'd1024; send(q);
        q = random_shade(); q.ray_angle = 12'd4095; q.player_angle = 12'd4095; send(q);
        // strip under two pixels tall
        q = random_shade(); q.ray_distance = 24'hFFFFFF; q.ray_angle = q.player_angle;
        q.row = 256; send(q);
        q.row = 255; send(q);
        // normal strip, rows across the screen
        for (int r = 0; r < 512; r += 128) begin
            q = random_shade(); q.ray_distance = 24'd22000; q.ray_angle = q.player_angle;
            q.row = r; send(q);
        end
        // bad texture numbers on wall rows give black
        q.ray_distance = '0; q.wall_content = 4'd0;  send(q);
        q.wall_content = 4'd9;  send(q);
        q.wall_content = 4'd15; send(q);
        // field extremes on texture one edge columns
        q = random_shade(); q.wall_content = 4'd1; q.hit_vertical = 1'b0;
        q.hit_x = 16'hFFFF; q.column = 10'd1023; q.ray_distance = '0; send(q);
        q.hit_x = 16'h0000; q.column = 10'd0; send(q);
        q.hit_vertical = 1'b1; q.hit_y = 16'hFFC0; q.hit_x = 16'hFFFF; send(q);
        // loads to a bad texture and to the top address are dropped or stored
        send(texel_load(4'd0, 12'hFFF));
        send(texel_load(4'd15, 12'h000));
        send(texel_load(4'd8, 12'hFFF));

        // Configuration phases, extremes included; the last one runs without idling.
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: write_regs(32'h0, 32'hFFFFFFFF, 16'd1);
                    2: write_regs(32'hFFFFFFFF, 32'h0, 16'hFFFF);
                    3: write_regs($urandom, $urandom, 16'd0);
                    4: write_regs($urandom, $urandom, $urandom_range(300, 1200));
                    default: write_regs($urandom, $urandom, 16'd692);
                endcase
                quiet = (p == 5);
            end
            for (int n = 0; n < 58; n++) begin
                case ($urandom_range(0, 99)) inside
                    [0:1]: begin
                        tex = $urandom_range(0, TEX_NUM - 1);
                        tx  = $urandom_range(0, TEX_W - 1);
                        fill_column(tex, tx);
                    end
                    [2:31]: send(texel_load($urandom_range(0, 15), $urandom));
                    default: send(random_shade());
                endcase
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: files.f
rtl/tws_pkg.sv
rtl/tws_fifo.sv
rtl/tws_front.sv
rtl/tws_back.sv
rtl/textured_wall_column_shader_unit.sv
bench/tws_pixel_checker.sv
bench/tb_textured_wall_column_shader_unit.sv
